// File: design/vnt_pkg.sv
// Shared constants for the value-noise turbulence block.
// No dependencies.
`default_nettype none
package vnt_pkg;
  localparam int TableEntries = 751;
  localparam int TableAw      = 10;
  localparam int WrapPeriod   = 100000;
  localparam int MaxOctaves   = 8;
  localparam int FracBits     = 16;
  localparam int CoordBits    = 34;
  localparam int HashMul      = 911;
  localparam int HashSpread   = 1000;
  // index reduction by reciprocal multiply, exact for any 32-bit hash
  localparam int HashShift    = 32 + TableAw;
  localparam logic [32:0] HashRecip =
    33'(((65'd1 << HashShift) + 65'(TableEntries) - 65'd1) / 65'(TableEntries));
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_EVAL   = 1'b1;
  localparam logic [0:0] REG_OCTAVES = 1'b0;
endpackage
`default_nettype wire

// File: design/vnt_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module vnt_ram #(
  parameter int Width = 16,
  parameter int Depth = 751
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: design/vnt_div.sv
// Restoring divider: 24-bit numerator by small denominator, one bit a cycle.
// Depends on vnt_pkg.
`default_nettype none
module vnt_div import vnt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [23:0] num,
  input  wire logic [8:0]  den,
  output logic             done,
  output logic [23:0]      quo
);
  logic [4:0]  cnt;
  logic        busy;
  logic [8:0]  rem;
  logic [9:0]  trial;
  assign trial = {rem, quo[23]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        rem  <= '0;
        quo  <= num;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= 9'(trial - {1'b0, den});
          quo <= {quo[22:0], 1'b1};
        end else begin
          rem <= trial[8:0];
          quo <= {quo[22:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: design/value_noise_turbulence.sv
// Value-noise turbulence top level: sequencer, arithmetic, config port.
// Depends on vnt_pkg, vnt_ram, vnt_div.
// A load transfer writes the lattice RAM as it is accepted. An evaluate runs octave_count
// octaves (clamped to 1..MaxOctaves) one after another; each octave folds each of the three
// axes (a nine-step period strip, then the smoothstep weight), then for each of the eight
// corners forms the hash, makes the two reads through the single RAM port and does the
// weighted accumulate, and finally adds the octave in. The 24-step divide and the output
// load follow. The next item is taken once the result has been transferred out.
`default_nettype none
module value_noise_turbulence import vnt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 valid,
  output logic                      ready,
  input  wire logic                 command,
  input  wire logic [9:0]           table_index,
  input  wire logic [15:0]          table_value,
  input  wire logic signed [33:0]   coord_x,
  input  wire logic signed [33:0]   coord_y,
  input  wire logic signed [33:0]   coord_z,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [15:0]               turbulence_value,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FOLD  = 10'b0000000010,
    S_RED   = 10'b0000000100,
    S_HASH  = 10'b0000001000,
    S_RDA   = 10'b0000010000,
    S_RDB   = 10'b0000100000,
    S_WGT   = 10'b0001000000,
    S_ACC   = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  localparam logic [63:0] Period = 64'(WrapPeriod) << FracBits;
  localparam logic [41:0] FoldTop = 42'(Period << 8);

  state_t state;
  logic [3:0]  octave_count;
  logic [3:0]  n_oct, k;
  logic signed [33:0] cx, cy, cz;
  logic [1:0]  axis;
  logic signed [41:0] scaled;
  logic [41:0] rem;          // folding remainder, stepped down by shifted period
  logic [41:0] pstep;
  logic [5:0]  fstep;
  logic [16:0] cell0 [3];
  logic [16:0] wt1 [3];
  logic [2:0]  corner;
  logic [2:0]  wsub;
  logic [31:0] ha, hb;
  logic [22:0] qa, qb;
  logic [9:0]  hred;
  logic [1:0]  hphase;
  logic [15:0] va;
  logic [16:0] w;
  logic [47:0] acc;
  logic [23:0] num;
  logic [15:0] f, f2;
  logic [31:0] prod;
  logic        div_start, div_done;
  logic [23:0] quo;
  logic        ram_we;
  logic [9:0]  ram_addr;
  logic [15:0] ram_rd;
  logic [16:0] cxs, cys, czs;
  logic [16:0] wa, wb, wc;

  assign pready = 1'b1;
  assign prdata = {28'd0, octave_count};
  assign ready  = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) octave_count <= 4'd5;
    else if (psel && penable && pwrite && paddr[2] == REG_OCTAVES && paddr[1:0] == 2'd0)
      octave_count <= pwdata[3:0];
  end

  vnt_ram #(.Width(16), .Depth(TableEntries)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(table_value), .rdata(ram_rd));

  assign ram_we = ready && valid && command == CMD_LOAD && table_index < 10'(TableEntries);

  vnt_div u_div (.clk(clk), .rst(rst), .start(div_start), .num(num),
                 .den(9'((9'd1 << n_oct) - 9'd1)), .done(div_done), .quo(quo));

  // corner selectors
  assign cxs = corner[2] ? ((cell0[0] == 17'(WrapPeriod-1)) ? 17'd0 : cell0[0] + 17'd1) : cell0[0];
  assign cys = corner[1] ? ((cell0[1] == 17'(WrapPeriod-1)) ? 17'd0 : cell0[1] + 17'd1) : cell0[1];
  assign czs = corner[0] ? ((cell0[2] == 17'(WrapPeriod-1)) ? 17'd0 : cell0[2] + 17'd1) : cell0[2];
  assign wa = corner[2] ? wt1[0] : 17'((17'd1 << FracBits) - wt1[0]);
  assign wb = corner[1] ? wt1[1] : 17'((17'd1 << FracBits) - wt1[1]);
  assign wc = corner[0] ? wt1[2] : 17'((17'd1 << FracBits) - wt1[2]);

  assign scaled = 42'((axis == 2'd0) ? cx : (axis == 2'd1) ? cy : cz) <<< k;

  always_comb begin
    ram_addr = ram_we ? table_index : hred;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (valid && ready && command == CMD_EVAL) begin
          cx <= coord_x; cy <= coord_y; cz <= coord_z;
          n_oct <= (octave_count == 4'd0) ? 4'd1 :
                   (octave_count > 4'(MaxOctaves)) ? 4'(MaxOctaves) : octave_count;
          k <= 4'd0; axis <= 2'd0; num <= '0; state <= S_FOLD;
        end
        S_FOLD: begin
          // offset by 256 periods so the value is non-negative, then strip periods
          rem   <= $unsigned(scaled) + FoldTop;
          pstep <= FoldTop;
          fstep <= 6'd0; state <= S_RED;
        end
        S_RED: begin
          if (fstep < 6'd9) begin
            if (rem >= pstep) rem <= rem - pstep;
            pstep <= pstep >> 1;
            fstep <= fstep + 6'd1;
          end else begin
            case (fstep)
              6'd9: begin
                cell0[axis] <= 17'(rem >> FracBits);
                f <= rem[15:0];
                prod <= rem[15:0] * rem[15:0];
                fstep <= 6'd10;
              end
              6'd10: begin
                f2 <= prod[31:16];
                fstep <= 6'd11;
              end
              default: begin
                wt1[axis] <= 17'((34'(f2) * ((34'(3) << FracBits) - 34'({f, 1'b0})))
                                 >> FracBits);
                if (axis == 2'd2) begin
                  axis <= 2'd0; corner <= 3'd0; acc <= '0; hphase <= 2'd0; state <= S_HASH;
                end else begin
                  axis <= axis + 2'd1; state <= S_FOLD;
                end
              end
            endcase
          end
        end
        S_HASH: begin
          case (hphase)
            2'd0: begin
              ha <= 32'(cxs) * 32'(HashMul) + 32'(cys);
              hb <= (32'(HashMul) + 32'(cxs) * 32'(HashSpread)) * 32'(HashMul) + 32'(cys) * 32'(HashSpread);
              hphase <= 2'd1;
            end
            2'd1: begin
              ha <= ha * 32'(HashMul) + 32'(czs);
              hb <= hb * 32'(HashMul) + 32'(czs) * 32'(HashSpread);
              hphase <= 2'd2;
            end
            2'd2: begin
              qa <= 23'((65'(ha) * 65'(HashRecip)) >> HashShift);
              qb <= 23'((65'(hb) * 65'(HashRecip)) >> HashShift);
              hphase <= 2'd3;
            end
            default: begin
              hred <= 10'(ha - 32'(qa) * 32'(TableEntries));
              hb   <= hb - 32'(qb) * 32'(TableEntries);
              state <= S_RDA;
            end
          endcase
        end
        S_RDA: begin
          hred <= hb[9:0];
          wsub <= 3'd0;
          state <= S_RDB;
        end
        S_RDB: begin
          if (wsub == 3'd0) begin
            va <= ram_rd; wsub <= 3'd1;
          end else begin
            va <= 16'(17'(va) + 17'(ram_rd));
            w  <= 17'((34'(wa) * 34'(wb)) >> FracBits);
            state <= S_WGT;
          end
        end
        S_WGT: begin
          w <= 17'((34'(w) * 34'(wc)) >> FracBits);
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + 48'(33'(w) * 33'(va));
          if (corner == 3'd7) begin
            state <= S_DIV; wsub <= 3'd0;
          end else begin
            corner <= corner + 3'd1; hphase <= 2'd0; state <= S_HASH;
          end
        end
        S_DIV: begin
          if (wsub == 3'd0) begin
            num <= num + (24'(acc >> FracBits) << (n_oct - 4'd1 - k));
            wsub <= 3'd1;
            if (k + 4'd1 != n_oct) begin
              k <= k + 4'd1; axis <= 2'd0; state <= S_FOLD;
            end else begin
              div_start <= 1'b1;
            end
          end else if (div_done) begin
            turbulence_value <= (quo > 24'd65535) ? 16'hFFFF : quo[15:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
